// ===== sv/vbbr_pkg.sv =====
// vbbr_pkg: shared types and constants for the vertex bounds box and radius block
// holds the coordinate width, word structs and the back-end state encoding
// no dependencies
package vbbr_pkg;

	// coordinate width and derived widths
	localparam int CoordBits = 16;
	// largest squared length is at most 3 * 2^(2*CoordBits-2), so 2*CoordBits bits hold it
	localparam int SqBits    = 2 * CoordBits;
	localparam int RemBits   = CoordBits + 2;
	localparam int StepBits  = $clog2(CoordBits + 1);

	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic        [CoordBits-1:0] radius_t;
	typedef logic        [SqBits-1:0]    sq_t;

	// input word: one vertex
	typedef struct packed {
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
		logic   last_vertex;
	} vtx_t;

	// output word: box corners and radius of one set
	typedef struct packed {
		coord_t  box_min_x;
		coord_t  box_min_y;
		coord_t  box_min_z;
		coord_t  box_max_x;
		coord_t  box_max_y;
		coord_t  box_max_z;
		radius_t bound_radius;
	} box_t;

	// finished set handed from front to back
	typedef struct packed {
		coord_t min_x;
		coord_t min_y;
		coord_t min_z;
		coord_t max_x;
		coord_t max_y;
		coord_t max_z;
		sq_t    max_sq;
	} set_t;

	// queue status seen by both ends
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// back-end sequencer states
	typedef enum logic [2:0] {
		BkIdle = 3'b001,
		BkRun  = 3'b010,
		BkDone = 3'b100
	} bk_state_t;

endpackage

// ===== sv/vbbr_front.sv =====
// vbbr_front: vertex intake, squaring pipeline and running bounds accumulation
// pushes one finished set per last vertex into the set queue
// depends on vbbr_pkg
module vbbr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vtx_valid,
	output logic               vtx_stall,
	input  vbbr_pkg::vtx_t     vtx,
	input  vbbr_pkg::q_stat_t  q_stat,
	output logic               q_push,
	output vbbr_pkg::set_t     q_data
);

	logic advance;
	logic in_fire;

	// stage 1: coordinates and per-axis squares
	logic                     s1_valid_s1;
	vbbr_pkg::vtx_t           vtx_s1;
	vbbr_pkg::sq_t            sq_x_s1, sq_y_s1, sq_z_s1;
	logic signed [vbbr_pkg::SqBits-1:0] prod_x, prod_y, prod_z;

	// stage 2: coordinates and squared length
	logic                     s2_valid_s2;
	vbbr_pkg::vtx_t           vtx_s2;
	vbbr_pkg::sq_t            sq_s2;

	// running bounds
	logic                     awaiting_first_q;
	vbbr_pkg::set_t           run_q;
	vbbr_pkg::set_t           run_next;
	logic                     acc_en;

	// whole front moves together; only a last vertex facing a full queue holds it
	assign advance   = !(s2_valid_s2 && vtx_s2.last_vertex && q_stat.full);
	assign vtx_stall = !advance;
	assign in_fire   = vtx_valid && advance;

	// signed squares, operands sign-extended to the product width
	assign prod_x = vbbr_pkg::SqBits'(vtx.pos_x) * vbbr_pkg::SqBits'(vtx.pos_x);
	assign prod_y = vbbr_pkg::SqBits'(vtx.pos_y) * vbbr_pkg::SqBits'(vtx.pos_y);
	assign prod_z = vbbr_pkg::SqBits'(vtx.pos_z) * vbbr_pkg::SqBits'(vtx.pos_z);

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			s2_valid_s2 <= 1'b0;
		end else if (advance) begin
			s1_valid_s1 <= in_fire;
			s2_valid_s2 <= s1_valid_s1;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (advance) begin
			vtx_s1  <= vtx;
			sq_x_s1 <= vbbr_pkg::sq_t'(prod_x);
			sq_y_s1 <= vbbr_pkg::sq_t'(prod_y);
			sq_z_s1 <= vbbr_pkg::sq_t'(prod_z);
			vtx_s2  <= vtx_s1;
			sq_s2   <= sq_x_s1 + sq_y_s1 + sq_z_s1;
		end
	end

	// fold the stage 2 vertex into the running bounds
	always_comb begin
		if (awaiting_first_q) begin
			run_next.min_x  = vtx_s2.pos_x;
			run_next.min_y  = vtx_s2.pos_y;
			run_next.min_z  = vtx_s2.pos_z;
			run_next.max_x  = vtx_s2.pos_x;
			run_next.max_y  = vtx_s2.pos_y;
			run_next.max_z  = vtx_s2.pos_z;
			run_next.max_sq = sq_s2;
		end else begin
			run_next.min_x  = (vtx_s2.pos_x < run_q.min_x) ? vtx_s2.pos_x : run_q.min_x;
			run_next.min_y  = (vtx_s2.pos_y < run_q.min_y) ? vtx_s2.pos_y : run_q.min_y;
			run_next.min_z  = (vtx_s2.pos_z < run_q.min_z) ? vtx_s2.pos_z : run_q.min_z;
			run_next.max_x  = (vtx_s2.pos_x > run_q.max_x) ? vtx_s2.pos_x : run_q.max_x;
			run_next.max_y  = (vtx_s2.pos_y > run_q.max_y) ? vtx_s2.pos_y : run_q.max_y;
			run_next.max_z  = (vtx_s2.pos_z > run_q.max_z) ? vtx_s2.pos_z : run_q.max_z;
			run_next.max_sq = (sq_s2 > run_q.max_sq) ? sq_s2 : run_q.max_sq;
		end
	end

	assign acc_en = s2_valid_s2 && advance;

	// running bounds and set-start flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_first_q <= 1'b1;
			run_q            <= '0;
		end else if (acc_en) begin
			awaiting_first_q <= vtx_s2.last_vertex;
			run_q            <= run_next;
		end
	end

	// hand the finished set to the queue
	assign q_push = acc_en && vtx_s2.last_vertex;
	assign q_data = run_next;

endmodule

// ===== sv/vbbr_queue.sv =====
// vbbr_queue: small fifo of finished sets between front and back
// register-file storage, one push and one pop per cycle
// depends on vbbr_pkg
module vbbr_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  vbbr_pkg::set_t     wr_data,
	input  logic               pop,
	output vbbr_pkg::set_t     rd_data,
	output vbbr_pkg::q_stat_t  stat
);

	localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntBits = $clog2(DEPTH + 1);
	localparam logic [PtrBits-1:0] LastPtr  = PtrBits'(DEPTH - 1);
	localparam logic [CntBits-1:0] FullCnt  = CntBits'(DEPTH);

	vbbr_pkg::set_t     mem [DEPTH];
	logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntBits-1:0] count_q;

	assign stat.full  = (count_q == FullCnt);
	assign stat.empty = (count_q == '0);
	assign rd_data    = mem[rd_ptr_q];

	// storage write
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/vbbr_back.sv =====
// vbbr_back: bit-serial integer square root and output word register
// takes one set from the queue, produces one result word
// depends on vbbr_pkg
module vbbr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  vbbr_pkg::q_stat_t  q_stat,
	input  vbbr_pkg::set_t     q_data,
	output logic               pop,
	output logic               box_valid,
	input  logic               box_stall,
	output vbbr_pkg::box_t     box
);

	localparam logic [vbbr_pkg::StepBits-1:0] LastStep =
		vbbr_pkg::StepBits'(vbbr_pkg::CoordBits - 1);

	vbbr_pkg::bk_state_t             state_q;
	vbbr_pkg::set_t                  set_q;
	vbbr_pkg::sq_t                   n_q;
	logic [vbbr_pkg::RemBits-1:0]    rem_q;
	vbbr_pkg::radius_t               root_q;
	logic [vbbr_pkg::StepBits-1:0]   step_q;
	logic                            out_valid_q;
	vbbr_pkg::box_t                  out_word_q;

	logic [vbbr_pkg::RemBits-1:0]    rem_sh;
	logic [vbbr_pkg::RemBits-1:0]    trial;
	logic                            take;
	logic                            out_free;
	logic                            load_out;

	// one root bit per step: bring down two bits, try root*4+1
	assign rem_sh = {rem_q[vbbr_pkg::CoordBits-1:0], n_q[vbbr_pkg::SqBits-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign take   = (rem_sh >= trial);

	assign pop      = (state_q == vbbr_pkg::BkIdle) && !q_stat.empty;
	assign out_free = !out_valid_q || !box_stall;
	assign load_out = (state_q == vbbr_pkg::BkDone) && out_free;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vbbr_pkg::BkIdle;
			step_q  <= '0;
		end else begin
			case (state_q)
				vbbr_pkg::BkIdle: begin
					if (pop) begin
						state_q <= vbbr_pkg::BkRun;
						step_q  <= '0;
					end
				end
				vbbr_pkg::BkRun: begin
					step_q <= step_q + 1'b1;
					if (step_q == LastStep) begin
						state_q <= vbbr_pkg::BkDone;
					end
				end
				vbbr_pkg::BkDone: begin
					if (out_free) begin
						state_q <= vbbr_pkg::BkIdle;
					end
				end
				default: state_q <= vbbr_pkg::BkIdle;
			endcase
		end
	end

	// root datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			set_q  <= q_data;
			n_q    <= q_data.max_sq;
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == vbbr_pkg::BkRun) begin
			n_q    <= n_q << 2;
			rem_q  <= take ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[vbbr_pkg::CoordBits-2:0], take};
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!box_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_word_q.box_min_x    <= set_q.min_x;
			out_word_q.box_min_y    <= set_q.min_y;
			out_word_q.box_min_z    <= set_q.min_z;
			out_word_q.box_max_x    <= set_q.max_x;
			out_word_q.box_max_y    <= set_q.max_y;
			out_word_q.box_max_z    <= set_q.max_z;
			out_word_q.bound_radius <= root_q;
		end
	end

	assign box_valid = out_valid_q;
	assign box       = out_word_q;

endmodule

// ===== sv/vertex_bounds_box_and_radius.sv =====
// vertex_bounds_box_and_radius: accepts one vertex word per cycle when not stalled.
// a last vertex passes stage 1 and stage 2 and is then pushed into the set queue; the back end pops it,
// works out the square root one radius bit per step and loads the output word.
// the back end pops a new set only from idle, so shorter sets queue up.
// arst_n clears pipeline valids, queue, sequencer and output valid; the next vertex opens a set.
// depends on vbbr_pkg, vbbr_front, vbbr_queue, vbbr_back
module vertex_bounds_box_and_radius #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vtx_valid,
	output logic            vtx_stall,
	input  vbbr_pkg::vtx_t  vtx,
	output logic            box_valid,
	input  logic            box_stall,
	output vbbr_pkg::box_t  box
);

	vbbr_pkg::q_stat_t q_stat;
	logic              q_push;
	logic              q_pop;
	vbbr_pkg::set_t    q_wr_data;
	vbbr_pkg::set_t    q_rd_data;

	// intake and accumulation
	vbbr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.vtx       (vtx),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_data    (q_wr_data)
	);

	// finished sets waiting for the root unit
	vbbr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr_data),
		.pop     (q_pop),
		.rd_data (q_rd_data),
		.stat    (q_stat)
	);

	// square root and output word
	vbbr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_data    (q_rd_data),
		.pop       (q_pop),
		.box_valid (box_valid),
		.box_stall (box_stall),
		.box       (box)
	);

	// a set is never pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("set pushed into full queue");

	// the back end never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("set popped from empty queue");

	// a delivered box is never inverted on any axis
	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid |-> (box.box_min_x <= box.box_max_x) && (box.box_min_y <= box.box_max_y)
			&& (box.box_min_z <= box.box_max_z))
		else $error("box corners out of order");

endmodule
